FILE: rtl/core/pstr_pkg.sv
// Shared types and constants of the shaded line and triangle rasterizer.
package pstr_pkg;

  localparam int NUM_LANES = 5;
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_R = 2;
  localparam int COORD_W = 11;
  localparam int COLOUR_W = 24;
  localparam int CHAN_W = 8;

  localparam logic [1:0] CMD_LINE = 2'd0;
  localparam logic [1:0] CMD_TRI  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  typedef struct packed {
    logic capture;
    logic setup;
    logic div_start;
    logic row_load;
    logic step;
    logic row_next;
    logic clear_wr;
    logic read_issue;
    logic result_load;
    logic tri_mode;
    logic result_read;
  } pstr_ctrl_t;

  typedef struct packed {
    logic div_done;
    logic clear_last;
  } pstr_stat_t;

endpackage

FILE: rtl/core/pstr_div.sv
// Constant divider by reciprocal multiplication: floor quotient, nonnegative remainder.
module pstr_div #(
  parameter int NUM_W   = 19,
  parameter int DEN_W   = 14,
  parameter int DIVISOR = 100
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] dividend,
  output logic                    done,
  output logic signed [NUM_W-1:0] quotient,
  output logic        [DEN_W-1:0] remainder
);

  localparam int MW = NUM_W + 1;
  localparam int PW = 2 * NUM_W + 1;
  localparam int SH = NUM_W + $clog2(DIVISOR);
  localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MW-1:0]    RECIP_W = MW'(RECIP);
  localparam logic [NUM_W-1:0] DIV_N   = NUM_W'(DIVISOR);
  localparam logic [DEN_W-1:0] DIV_D   = DEN_W'(DIVISOR);

  logic             neg;
  logic [NUM_W-1:0] mag;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [1:0]       stage;
  logic [PW-1:0]    prod;
  logic [NUM_W-1:0] qd;
  logic             rem_nz;

  assign prod   = PW'(mag) * PW'(RECIP_W);
  assign qd     = NUM_W'(quo * DIV_N);
  assign rem_nz = rem != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= 2'b00;
      done  <= 1'b0;
    end else begin
      stage <= {stage[0], start};
      if (start) begin
        done <= 1'b0;
      end else if (stage[1]) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[NUM_W-1];
      mag <= dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
    end
    if (stage[0]) begin
      quo <= NUM_W'(prod >> SH);
    end
    if (stage[1]) begin
      rem <= DEN_W'(mag - qd);
    end
  end

  always_comb begin
    if (neg && rem_nz) begin
      quotient  = $signed(~quo);
      remainder = DIV_D - rem;
    end else if (neg) begin
      quotient  = $signed(-quo);
      remainder = rem;
    end else begin
      quotient  = $signed(quo);
      remainder = rem;
    end
  end

endmodule

FILE: rtl/core/pstr_datapath.sv
// Datapath: vertex registers, per-lane dividers and steppers, pixel pipeline and frame store.
module pstr_datapath #(
  parameter int FRAME_WIDTH  = 64,
  parameter int FRAME_HEIGHT = 64,
  parameter int STEPS        = 100
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pstr_pkg::pstr_ctrl_t                  ctrl,
  output pstr_pkg::pstr_stat_t                  stat,
  input  logic signed [pstr_pkg::COORD_W-1:0]   vx_a,
  input  logic signed [pstr_pkg::COORD_W-1:0]   vy_a,
  input  logic signed [pstr_pkg::COORD_W-1:0]   vx_b,
  input  logic signed [pstr_pkg::COORD_W-1:0]   vy_b,
  input  logic signed [pstr_pkg::COORD_W-1:0]   vx_c,
  input  logic signed [pstr_pkg::COORD_W-1:0]   vy_c,
  input  logic        [pstr_pkg::COLOUR_W-1:0]  colour_a,
  input  logic        [pstr_pkg::COLOUR_W-1:0]  colour_b,
  input  logic        [pstr_pkg::COLOUR_W-1:0]  colour_c,
  output logic        [pstr_pkg::COLOUR_W-1:0]  pixel_colour,
  output logic                                  in_bounds
);

  import pstr_pkg::*;

  localparam int SW    = $clog2(STEPS + 1);
  localparam int NUM_W = SW + 12;
  localparam int DEN_W = $clog2(STEPS * STEPS + 1);
  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic        [DEN_W-1:0] S_DEN  = DEN_W'(STEPS);
  localparam logic        [DEN_W-1:0] S2_DEN = DEN_W'(STEPS * STEPS);
  localparam logic signed [NUM_W-1:0] S_NUM  = NUM_W'(STEPS);

  logic signed [COORD_W-1:0]  vx_a_r, vy_a_r, vx_b_r, vy_b_r, vx_c_r, vy_c_r;
  logic        [COLOUR_W-1:0] colour_a_r, colour_b_r, colour_c_r;

  logic signed [NUM_W-1:0] lane_a [NUM_LANES];
  logic signed [NUM_W-1:0] lane_b [NUM_LANES];
  logic signed [NUM_W-1:0] lane_c [NUM_LANES];
  logic signed [NUM_W-1:0] lane_l [NUM_LANES];
  logic signed [NUM_W-1:0] lane_sc [NUM_LANES];
  logic signed [NUM_W-1:0] delta_num [NUM_LANES];
  logic signed [NUM_W-1:0] st_q [NUM_LANES];
  logic        [DEN_W-1:0] st_r [NUM_LANES];
  logic signed [NUM_W-1:0] dl_q [NUM_LANES];
  logic        [DEN_W-1:0] dl_r [NUM_LANES];
  logic signed [NUM_W-1:0] step_q [NUM_LANES];
  logic        [DEN_W-1:0] step_r [NUM_LANES];
  logic signed [NUM_W-1:0] step_dq [NUM_LANES];
  logic        [DEN_W-1:0] step_dr [NUM_LANES];
  logic signed [NUM_W-1:0] rnd [NUM_LANES];
  logic [2*NUM_LANES-1:0]  done_vec;

  logic signed [NUM_W-1:0]  px, py;
  logic [COLOUR_W-1:0]      prgb;
  logic                     v1;
  logic                     p_inb;
  logic [AW-1:0]            waddr;
  logic [COLOUR_W-1:0]      wrgb;
  logic                     v2;

  logic [COLOUR_W-1:0] mem [DEPTH];
  logic [AW-1:0]       clr_addr;
  logic [COLOUR_W-1:0] rd_data;
  logic                rd_inb;
  logic [AW-1:0]       rd_addr;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      vx_a_r     <= vx_a;
      vy_a_r     <= vy_a;
      vx_b_r     <= vx_b;
      vy_b_r     <= vy_b;
      vx_c_r     <= vx_c;
      vy_c_r     <= vy_c;
      colour_a_r <= colour_a;
      colour_b_r <= colour_b;
      colour_c_r <= colour_c;
    end
  end

  always_comb begin
    lane_a[LANE_X] = NUM_W'(vx_a_r);
    lane_b[LANE_X] = NUM_W'(vx_b_r);
    lane_c[LANE_X] = NUM_W'(vx_c_r);
    lane_a[LANE_Y] = NUM_W'(vy_a_r);
    lane_b[LANE_Y] = NUM_W'(vy_b_r);
    lane_c[LANE_Y] = NUM_W'(vy_c_r);
    for (int ch = 0; ch < 3; ch++) begin
      lane_a[LANE_R + ch] = $signed(NUM_W'(colour_a_r[(2 - ch) * CHAN_W +: CHAN_W]));
      lane_b[LANE_R + ch] = $signed(NUM_W'(colour_b_r[(2 - ch) * CHAN_W +: CHAN_W]));
      lane_c[LANE_R + ch] = $signed(NUM_W'(colour_c_r[(2 - ch) * CHAN_W +: CHAN_W]));
    end
  end

  // Points are stepped as a quotient and a remainder over STEPS * STEPS.
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    logic [DEN_W:0] r_sum;
    logic           carry;
    logic [DEN_W:0] twice_r;
    logic           rbit;

    assign delta_num[i] = ctrl.tri_mode ? (lane_sc[i] - lane_l[i])
                                        : NUM_W'(S_NUM * (lane_b[i] - lane_a[i]));

    pstr_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .DIVISOR(STEPS)) u_start_div (
      .clk       (clk),
      .rst       (rst),
      .start     (ctrl.div_start),
      .dividend  (lane_l[i]),
      .done      (done_vec[2*i]),
      .quotient  (st_q[i]),
      .remainder (st_r[i])
    );

    pstr_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .DIVISOR(STEPS * STEPS)) u_delta_div (
      .clk       (clk),
      .rst       (rst),
      .start     (ctrl.div_start),
      .dividend  (delta_num[i]),
      .done      (done_vec[2*i+1]),
      .quotient  (dl_q[i]),
      .remainder (dl_r[i])
    );

    assign r_sum   = {1'b0, step_r[i]} + {1'b0, step_dr[i]};
    assign carry   = r_sum >= {1'b0, S2_DEN};
    assign twice_r = {step_r[i], 1'b0};
    assign rbit    = step_q[i][NUM_W-1] ? (twice_r > {1'b0, S2_DEN})
                                        : (twice_r >= {1'b0, S2_DEN});
    assign rnd[i]  = step_q[i] + $signed(NUM_W'(rbit));

    always_ff @(posedge clk) begin
      if (ctrl.setup) begin
        lane_l[i]  <= NUM_W'(S_NUM * lane_a[i]);
        lane_sc[i] <= NUM_W'(S_NUM * lane_c[i]);
      end else if (ctrl.row_next) begin
        lane_l[i] <= lane_l[i] + (lane_b[i] - lane_a[i]);
      end
      if (ctrl.row_load) begin
        step_q[i]  <= st_q[i];
        step_r[i]  <= DEN_W'(st_r[i] * S_DEN);
        step_dq[i] <= dl_q[i];
        step_dr[i] <= dl_r[i];
      end else if (ctrl.step) begin
        step_q[i] <= step_q[i] + step_dq[i] + $signed(NUM_W'(carry));
        step_r[i] <= carry ? DEN_W'(r_sum - {1'b0, S2_DEN}) : r_sum[DEN_W-1:0];
      end
    end
  end

  assign stat.div_done   = &done_vec;
  assign stat.clear_last = clr_addr == AW'(DEPTH - 1);

  // Two-stage pixel pipeline: rounded point, then bounds check and address.
  assign p_inb = (px >= 0) && (px < FRAME_WIDTH) && (py >= 0) && (py < FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctrl.step;
      v2 <= v1 && p_inb;
    end
  end

  always_ff @(posedge clk) begin
    px    <= rnd[LANE_X];
    py    <= rnd[LANE_Y];
    prgb  <= {rnd[LANE_R][CHAN_W-1:0], rnd[LANE_R+1][CHAN_W-1:0], rnd[LANE_R+2][CHAN_W-1:0]};
    waddr <= AW'(px * FRAME_HEIGHT + py);
    wrgb  <= prgb;
  end

  assign rd_inb  = (vx_a_r >= 0) && (vx_a_r < FRAME_WIDTH) &&
                   (vy_a_r >= 0) && (vy_a_r < FRAME_HEIGHT);
  assign rd_addr = AW'(vx_a_r * FRAME_HEIGHT + vy_a_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctrl.clear_wr && !stat.clear_last) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear_wr) begin
      mem[clr_addr] <= '0;
    end else if (v2) begin
      mem[waddr] <= wrgb;
    end
    if (ctrl.read_issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.result_load) begin
      pixel_colour <= (ctrl.result_read && rd_inb) ? rd_data : '0;
      in_bounds    <= ctrl.result_read && rd_inb;
    end
  end

endmodule

FILE: rtl/core/pstr_ctrl.sv
// Controller: sequences clearing, row division, point stepping, reads and results.
module pstr_ctrl #(
  parameter int STEPS = 100
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           cmd,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pstr_pkg::pstr_ctrl_t ctrl,
  input  pstr_pkg::pstr_stat_t stat
);

  import pstr_pkg::*;

  localparam int SW = $clog2(STEPS + 1);
  localparam logic [SW-1:0] LAST = SW'(STEPS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SETUP, S_START, S_DIV, S_STEP, S_DRAIN, S_READ, S_DONE
  } state_t;

  state_t        state;
  logic [1:0]    mode;
  logic [SW-1:0] outer_step;
  logic [SW-1:0] inner_step;
  logic          drain;
  logic          out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      mode       <= CMD_LINE;
      outer_step <= '0;
      inner_step <= '0;
      drain      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= ctrl.result_load || (out_valid && out_stall);
      case (state)
        S_CLEAR: begin
          if (stat.clear_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            mode <= cmd;
            case (cmd) inside
              CMD_LINE, CMD_TRI: state <= S_SETUP;
              CMD_READ:          state <= S_READ;
              default:           state <= S_DONE;
            endcase
          end
        end
        S_SETUP: begin
          outer_step <= '0;
          state      <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (stat.div_done) begin
            inner_step <= '0;
            state      <= S_STEP;
          end
        end
        S_STEP: begin
          if (inner_step == LAST) begin
            inner_step <= '0;
            if (mode != CMD_TRI || outer_step == LAST) begin
              outer_step <= '0;
              drain      <= 1'b0;
              state      <= S_DRAIN;
            end else begin
              outer_step <= outer_step + 1'b1;
              state      <= S_START;
            end
          end else begin
            inner_step <= inner_step + 1'b1;
          end
        end
        S_DRAIN: begin
          drain <= 1'b1;
          if (drain) begin
            state <= S_DONE;
          end
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    ctrl             = '0;
    ctrl.capture     = (state == S_IDLE) && in_valid;
    ctrl.setup       = state == S_SETUP;
    ctrl.div_start   = state == S_START;
    ctrl.row_load    = (state == S_DIV) && stat.div_done;
    ctrl.step        = state == S_STEP;
    ctrl.row_next    = (state == S_STEP) && (inner_step == LAST) &&
                       (mode == CMD_TRI) && (outer_step != LAST);
    ctrl.clear_wr    = state == S_CLEAR;
    ctrl.read_issue  = state == S_READ;
    ctrl.result_load = (state == S_DONE) && out_free;
    ctrl.tri_mode    = mode == CMD_TRI;
    ctrl.result_read = mode == CMD_READ;
  end

endmodule

FILE: rtl/core/parametric_shaded_triangle_rasterizer.sv
// Top level of the shaded line and triangle rasterizer with its frame store.
//
// One command is taken per transfer on the input channel (in_valid, in_stall):
// draw a shaded line, draw a shaded triangle, or read one pixel. Every command
// gives exactly one result transfer on the output channel (out_valid,
// out_stall); draw commands return zero, a read returns the pixel colour and
// whether the position lies inside the frame.
// Commands are handled one at a time, and the next transfer is taken in the
// cycle the result appears. Each row needs a division by the per-lane dividers
// and then steps one point per cycle, writing those inside the frame; a line is
// one row and a triangle STEPS + 1 rows. After reset the frame store is cleared
// to black one pixel per cycle, and in_stall stays high meanwhile.
// A finished result waits in the output register while the receiver stalls;
// the next command is taken meanwhile, and its own result waits until the
// register is free.
module parametric_shaded_triangle_rasterizer #(
  parameter int FRAME_WIDTH  = 64,
  parameter int FRAME_HEIGHT = 64,
  parameter int STEPS        = 100
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           cmd,
  input  logic signed [pstr_pkg::COORD_W-1:0]  vx_a,
  input  logic signed [pstr_pkg::COORD_W-1:0]  vy_a,
  input  logic signed [pstr_pkg::COORD_W-1:0]  vx_b,
  input  logic signed [pstr_pkg::COORD_W-1:0]  vy_b,
  input  logic signed [pstr_pkg::COORD_W-1:0]  vx_c,
  input  logic signed [pstr_pkg::COORD_W-1:0]  vy_c,
  input  logic        [pstr_pkg::COLOUR_W-1:0] colour_a,
  input  logic        [pstr_pkg::COLOUR_W-1:0] colour_b,
  input  logic        [pstr_pkg::COLOUR_W-1:0] colour_c,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [pstr_pkg::COLOUR_W-1:0] pixel_colour,
  output logic                                 in_bounds
);

  import pstr_pkg::*;

  pstr_ctrl_t ctrl;
  pstr_stat_t stat;

  pstr_ctrl #(.STEPS(STEPS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  pstr_datapath #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .STEPS        (STEPS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .vx_a         (vx_a),
    .vy_a         (vy_a),
    .vx_b         (vx_b),
    .vy_b         (vy_b),
    .vx_c         (vx_c),
    .vy_c         (vy_c),
    .colour_a     (colour_a),
    .colour_b     (colour_b),
    .colour_c     (colour_c),
    .pixel_colour (pixel_colour),
    .in_bounds    (in_bounds)
  );

endmodule

FILE: bench/parametric_shaded_triangle_rasterizer_tb.sv
// Self-checking testbench for the shaded line and triangle rasterizer.
module parametric_shaded_triangle_rasterizer_tb;
  import pstr_pkg::*;

  localparam int FW = 64;
  localparam int FH = 64;
  localparam int NSTEP = 100;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam longint CYCLE_LIMIT = 10000000;

  typedef struct {
    logic [1:0] op;
    logic signed [10:0] xa, ya, xb, yb, xc, yc;
    logic [23:0] ca, cb, cc;
    bit known;
    logic [23:0] want_colour;
    logic want_inb;
  } cmd_row_t;

  typedef struct {
    logic [23:0] colour;
    logic inb;
  } pixel_result_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] cmd = 0;
  logic signed [10:0] vx_a = 0, vy_a = 0, vx_b = 0, vy_b = 0, vx_c = 0, vy_c = 0;
  logic [23:0] colour_a = 0, colour_b = 0, colour_c = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [23:0] pixel_colour;
  logic in_bounds;

  logic [23:0] shadow_frame [FW*FH];
  pixel_result_t pending_results [$];
  cmd_row_t directed_rows [$];
  int error_count = 0;
  longint cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  parametric_shaded_triangle_rasterizer #(
    .FRAME_WIDTH(FW), .FRAME_HEIGHT(FH), .STEPS(NSTEP)
  ) uut (.*);

  always #4 clk = ~clk;

  function automatic longint div_round(longint num, longint den);
    longint mag;
    longint q;
    mag = num < 0 ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return num < 0 ? -q : q;
  endfunction

  function automatic void plot_pixel(longint x, longint y, logic [23:0] rgb);
    if (x >= 0 && x < FW && y >= 0 && y < FH) shadow_frame[x * FH + y] = rgb;
  endfunction

  function automatic pixel_result_t predict_command(cmd_row_t c);
    pixel_result_t r;
    longint s;
    longint d;
    longint wa;
    longint wb;
    longint wc;
    logic [23:0] rgb;
    s = NSTEP;
    d = s * s;
    r.colour = 0;
    r.inb = 0;
    if (c.op == CMD_LINE) begin
      for (int k = 0; k <= NSTEP; k++) begin
        wa = s - k;
        for (int sh = 0; sh < 24; sh += 8)
          rgb[sh +: 8] = 8'(div_round(wa * c.ca[sh +: 8] + k * c.cb[sh +: 8], s));
        plot_pixel(div_round(wa * c.xa + k * c.xb, s), div_round(wa * c.ya + k * c.yb, s), rgb);
      end
    end else if (c.op == CMD_TRI) begin
      for (int k = 0; k <= NSTEP; k++) begin
        for (int m = 0; m <= NSTEP; m++) begin
          wa = (s - m) * (s - k);
          wb = (s - m) * k;
          wc = m * s;
          for (int sh = 0; sh < 24; sh += 8)
            rgb[sh +: 8] = 8'(div_round(wa * c.ca[sh +: 8] + wb * c.cb[sh +: 8]
                                        + wc * c.cc[sh +: 8], d));
          plot_pixel(div_round(wa * c.xa + wb * c.xb + wc * c.xc, d),
                     div_round(wa * c.ya + wb * c.yb + wc * c.yc, d), rgb);
        end
      end
    end else if (c.op == CMD_READ) begin
      if (c.xa >= 0 && c.xa < FW && c.ya >= 0 && c.ya < FH) begin
        r.colour = shadow_frame[c.xa * FH + c.ya];
        r.inb = 1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
    $display("Mismatch in %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  function automatic cmd_row_t make_row(logic [1:0] op, int xa, int ya, int xb, int yb,
                                        int xc, int yc, logic [23:0] ca, logic [23:0] cb,
                                        logic [23:0] cc);
    cmd_row_t c;
    c.op = op;
    c.xa = 11'(xa); c.ya = 11'(ya); c.xb = 11'(xb); c.yb = 11'(yb);
    c.xc = 11'(xc); c.yc = 11'(yc);
    c.ca = ca; c.cb = cb; c.cc = cc;
    c.known = 0;
    c.want_colour = 0;
    c.want_inb = 0;
    return c;
  endfunction

  function automatic cmd_row_t make_known(cmd_row_t c, logic [23:0] col, logic inb);
    c.known = 1;
    c.want_colour = col;
    c.want_inb = inb;
    return c;
  endfunction

  function automatic void add_row(cmd_row_t c);
    directed_rows = {directed_rows, c};
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 2047) - 1024;
      1: return $urandom_range(0, 1) ? 1023 : -1024;
      2: return $urandom_range(0, 8) - 4;
      3: return $urandom_range(FW - 3, FW + 3);
      default: return $urandom_range(0, FW - 1);
    endcase
  endfunction

  function automatic cmd_row_t random_row();
    int pick;
    logic [1:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 45) op = CMD_READ;
    else if (pick < 75) op = CMD_LINE;
    else if (pick < 95) op = CMD_TRI;
    else op = CMD_NONE;
    return make_row(op, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), 24'($urandom), 24'($urandom),
                    24'($urandom));
  endfunction

  task automatic send_command(cmd_row_t c);
    pixel_result_t r;
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    cmd <= c.op;
    vx_a <= c.xa; vy_a <= c.ya; vx_b <= c.xb; vy_b <= c.yb; vx_c <= c.xc; vy_c <= c.yc;
    colour_a <= c.ca; colour_b <= c.cb; colour_c <= c.cc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_command(c);
    if (c.known) begin
      r.colour = c.want_colour;
      r.inb = c.want_inb;
    end
    pending_results = {pending_results, r};
  endtask

  always @(posedge clk) begin
    pixel_result_t e;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", pixel_colour, 24'h0);
      end else begin
        e = pending_results.pop_front();
        if (pixel_colour !== e.colour) report_mismatch("pixel_colour", pixel_colour, e.colour);
        if (in_bounds !== e.inb) report_mismatch("in_bounds", 24'(in_bounds), 24'(e.inb));
      end
    end
    out_stall <= (recv_stall_pct > 0 && $urandom_range(0, 99) < recv_stall_pct);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    cmd_row_t c;
    for (int i = 0; i < FW * FH; i++) shadow_frame[i] = 0;
    add_row(make_known(make_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 24'h0, 1));
    add_row(make_known(make_row(CMD_READ, FW - 1, FH - 1, 0, 0, 0, 0, 0, 0, 0),
                       24'h0, 1));
    add_row(make_known(make_row(CMD_READ, -1, 0, 0, 0, 0, 0, 0, 0, 0), 24'h0, 0));
    add_row(make_known(make_row(CMD_READ, 0, FH, 0, 0, 0, 0, 0, 0, 0), 24'h0, 0));
    add_row(make_known(make_row(CMD_READ, 1023, -1024, 0, 0, 0, 0, 0, 0, 0), 24'h0, 0));
    add_row(make_known(make_row(CMD_NONE, 5, 5, 9, 9, 1, 1, 24'hFFFFFF, 24'hFFFFFF,
                                24'hFFFFFF), 24'h0, 0));
    add_row(make_known(make_row(CMD_LINE, 0, 0, FW - 1, FH - 1, 0, 0, 24'hFFFFFF,
                                24'h000000, 0), 24'h0, 0));
    add_row(make_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_row(CMD_READ, FW - 1, FH - 1, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_row(CMD_READ, 31, 31, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_row(CMD_LINE, -1024, 1023, 1023, -1024, 0, 0, 24'h123456, 24'hFEDCBA, 0));
    add_row(make_row(CMD_LINE, 0, 5, 0, 5, 0, 0, 24'hAA55AA, 24'hAA55AA, 0));
    add_row(make_row(CMD_READ, 0, 5, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_row(CMD_LINE, -1, -1, 2, 2, 0, 0, 24'h0000FF, 24'hFF0000, 0));
    add_row(make_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_row(CMD_TRI, 0, 0, FW - 1, 0, 0, FH - 1, 24'hFF0000, 24'h00FF00,
                     24'h0000FF));
    add_row(make_row(CMD_READ, 10, 10, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_row(CMD_READ, 0, FH - 1, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_row(CMD_TRI, -1024, -1024, 1023, 1023, 1023, -1024, 24'hFFFFFF,
                     24'h000000, 24'h808080));
    add_row(make_row(CMD_READ, 40, 2, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_row(CMD_TRI, -3, -3, -3, 70, 70, -3, 24'h010203, 24'hFDFEFF,
                     24'h7F8081));
    add_row(make_row(CMD_READ, 20, 20, 0, 0, 0, 0, 0, 0, 0));
    repeat (9) @(posedge clk);
    rst <= 0;
    foreach (directed_rows[i]) send_command(directed_rows[i]);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 48; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 48; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      for (int n = 0; n < 20; n++) begin
        c = random_row();
        send_command(c);
      end
    end
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

FILE: parametric_shaded_triangle_rasterizer.f
rtl/core/pstr_pkg.sv
rtl/core/pstr_div.sv
rtl/core/pstr_datapath.sv
rtl/core/pstr_ctrl.sv
rtl/core/parametric_shaded_triangle_rasterizer.sv
bench/parametric_shaded_triangle_rasterizer_tb.sv
